/* design/pccd_pkg.sv */
package pccd_pkg;

  localparam int unsigned TableEntriesDefault = 256;
  localparam int unsigned HandleBitsDefault   = 32;

  localparam int unsigned HandleW = 32;
  localparam int unsigned TagW    = 16;
  localparam int unsigned StatusW = 3;

  localparam logic [StatusW-1:0] StTracked = 3'd0;
  localparam logic [StatusW-1:0] StFull    = 3'd1;
  localparam logic [StatusW-1:0] StNoCycle = 3'd2;
  localparam logic [StatusW-1:0] StCycle   = 3'd3;
  localparam logic [StatusW-1:0] StNull    = 3'd4;

  typedef enum logic [1:0] {
    OP_TRACK  = 2'd0,
    OP_NULL   = 2'd1,
    OP_ASSIGN = 2'd2
  } op_e;

  // Classified command passed from the front queue to the engine.
  typedef struct packed {
    op_e               op;
    logic [HandleW-1:0] a;
    logic [HandleW-1:0] b;
    logic [TagW-1:0]    tag;
  } cmd_t;

endpackage

/* design/pccd_if.sv */
interface pccd_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [pccd_pkg::HandleW-1:0]  first_handle;
  logic [pccd_pkg::HandleW-1:0]  second_handle;
  logic [pccd_pkg::TagW-1:0]     name_tag;

  modport source (output valid, action, first_handle, second_handle, name_tag, input ready);
  modport sink   (input valid, action, first_handle, second_handle, name_tag, output ready);
endinterface

interface pccd_out_if;
  logic                          valid;
  logic                          ready;
  logic [pccd_pkg::StatusW-1:0]  status;
  logic [pccd_pkg::TagW-1:0]     parent_tag;
  logic                          parent_known;
  logic [pccd_pkg::TagW-1:0]     child_tag;
  logic                          child_known;

  modport source (output valid, status, parent_tag, parent_known, child_tag, child_known,
                  input ready);
  modport sink   (input valid, status, parent_tag, parent_known, child_tag, child_known,
                  output ready);
endinterface

/* design/pccd_front.sv */
module pccd_front #(
  parameter int unsigned HANDLE_BITS = pccd_pkg::HandleBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pccd_in_if.sink           in_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output pccd_pkg::cmd_t    cmd_o
);

  localparam logic [pccd_pkg::HandleW-1:0] HandleMask =
    (HANDLE_BITS >= pccd_pkg::HandleW) ? '1 :
    pccd_pkg::HandleW'((64'd1 << HANDLE_BITS) - 64'd1);

  pccd_pkg::cmd_t fifo_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q;
  pccd_pkg::cmd_t cls;
  logic           push, pop;

  // Mask handles and classify the beat.
  always_comb begin
    cls.a   = in_i.first_handle & HandleMask;
    cls.b   = in_i.second_handle & HandleMask;
    cls.tag = in_i.name_tag;
    priority if (!in_i.action) begin
      cls.op = pccd_pkg::OP_TRACK;
    end else if (cls.a == '0 || cls.b == '0) begin
      cls.op = pccd_pkg::OP_NULL;
    end else begin
      cls.op = pccd_pkg::OP_ASSIGN;
    end
  end

  assign in_i.ready  = (cnt_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

/* design/pccd_back.sv */
module pccd_back #(
  parameter int unsigned TABLE_ENTRIES = pccd_pkg::TableEntriesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  pccd_pkg::cmd_t    cmd_i,
  pccd_out_if.source        out_o
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CntW-1:0] Full = CntW'(TABLE_ENTRIES);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHILD = 8'b0000_0010,
    S_CHECK = 8'b0000_0100,
    S_WSCAN = 8'b0000_1000,
    S_LADDR = 8'b0001_0000,
    S_LDATA = 8'b0010_0000,
    S_TAGS  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  logic [pccd_pkg::HandleW-1:0] keys  [TABLE_ENTRIES];
  logic [pccd_pkg::HandleW-1:0] links [TABLE_ENTRIES];
  logic [pccd_pkg::TagW-1:0]    tags  [TABLE_ENTRIES];

  state_e                       st_q, st_d;
  logic [CntW-1:0]              count_q, count_d, scan_q, scan_d, depth_q, depth_d;
  logic                         pend_q, pend_d;
  logic [IdxW-1:0]              pidx_q, k_q, k_d;
  logic [pccd_pkg::HandleW-1:0] a_q, a_d, b_q, b_d, cur_q, cur_d;
  logic [pccd_pkg::StatusW-1:0] status_q, status_d;
  logic [pccd_pkg::TagW-1:0]    ptag_q, ptag_d, ctag_q, ctag_d;
  logic                         pk_q, pk_d, ck_q, ck_d;
  logic                         ovalid_q, ovalid_d, load;

  logic [pccd_pkg::HandleW-1:0] key_rd_q, link_rd_q;
  logic [pccd_pkg::TagW-1:0]    tag_rd_q;
  logic [IdxW-1:0]              rd_addr, waddr;
  logic                         we_key, we_link, issue;
  logic [pccd_pkg::HandleW-1:0] wkey, wlink;
  logic [pccd_pkg::TagW-1:0]    wtag;

  assign issue       = (scan_q < count_q);
  assign cmd_ready_o = (st_q == S_IDLE);

  always_comb begin
    st_d = st_q;  count_d = count_q;  scan_d = scan_q;  depth_d = depth_q;
    pend_d = 1'b0;  k_d = k_q;  a_d = a_q;  b_d = b_q;  cur_d = cur_q;
    status_d = status_q;  ptag_d = ptag_q;  ctag_d = ctag_q;  pk_d = pk_q;  ck_d = ck_q;
    rd_addr = scan_q[IdxW-1:0];
    we_key = 1'b0;  we_link = 1'b0;
    waddr = count_q[IdxW-1:0];  wkey = cmd_i.a;  wtag = cmd_i.tag;  wlink = '0;
    load = 1'b0;

    unique case (st_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          ptag_d = '0;  ctag_d = '0;  pk_d = 1'b0;  ck_d = 1'b0;
          a_d = cmd_i.a;  b_d = cmd_i.b;
          st_d = S_DONE;
          unique case (cmd_i.op)
            pccd_pkg::OP_TRACK: begin
              if (count_q < Full) begin
                we_key = 1'b1;  we_link = 1'b1;
                count_d = count_q + 1'b1;
                status_d = pccd_pkg::StTracked;
              end else begin
                status_d = pccd_pkg::StFull;
              end
            end
            pccd_pkg::OP_NULL: status_d = pccd_pkg::StNull;
            default: begin
              // First match of the child takes the new link, then the walk.
              scan_d = '0;  cur_d = cmd_i.a;  depth_d = '0;
              st_d = S_CHILD;
            end
          endcase
        end
      end
      S_CHILD: begin
        pend_d = issue;
        if (issue) scan_d = scan_q + 1'b1;
        if (pend_q && key_rd_q == b_q) begin
          we_link = 1'b1;  waddr = pidx_q;  wlink = a_q;
          st_d = S_CHECK;
        end else if (!pend_q && !issue) begin
          st_d = S_CHECK;
        end
      end
      S_CHECK: begin
        scan_d = '0;
        priority if (cur_q == '0 || depth_q == Full) begin
          status_d = pccd_pkg::StNoCycle;
          st_d = S_DONE;
        end else if (cur_q == b_q) begin
          st_d = S_TAGS;
        end else begin
          depth_d = depth_q + 1'b1;
          st_d = S_WSCAN;
        end
      end
      S_WSCAN: begin
        pend_d = issue;
        if (issue) scan_d = scan_q + 1'b1;
        if (pend_q && key_rd_q == cur_q) begin
          k_d = pidx_q;
          st_d = S_LADDR;
        end else if (!pend_q && !issue) begin
          // Unknown handle: treat its parent as null.
          cur_d = '0;
          st_d = S_CHECK;
        end
      end
      S_LADDR: begin
        rd_addr = k_q;
        st_d = S_LDATA;
      end
      S_LDATA: begin
        cur_d = link_rd_q;
        st_d = S_CHECK;
      end
      S_TAGS: begin
        pend_d = issue;
        if (issue) scan_d = scan_q + 1'b1;
        if (pend_q && key_rd_q == a_q) begin
          ptag_d = tag_rd_q;  pk_d = 1'b1;
        end
        if (pend_q && key_rd_q == b_q) begin
          ctag_d = tag_rd_q;  ck_d = 1'b1;
        end
        if (!pend_q && !issue) begin
          status_d = pccd_pkg::StCycle;
          st_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!ovalid_q || out_o.ready) begin
          load = 1'b1;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  assign ovalid_d = load || (ovalid_q && !out_o.ready);

  always_ff @(posedge clk_i) begin
    if (we_key) begin
      keys[waddr] <= wkey;
      tags[waddr] <= wtag;
    end
    if (we_link) begin
      links[waddr] <= wlink;
    end
    key_rd_q  <= keys[rd_addr];
    tag_rd_q  <= tags[rd_addr];
    link_rd_q <= links[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= scan_q[IdxW-1:0];
    k_q <= k_d;  a_q <= a_d;  b_q <= b_d;  cur_q <= cur_d;  depth_q <= depth_d;
    status_q <= status_d;  ptag_q <= ptag_d;  ctag_q <= ctag_d;  pk_q <= pk_d;  ck_q <= ck_d;
    if (load) begin
      out_o.status       <= status_q;
      out_o.parent_tag   <= ptag_q;
      out_o.parent_known <= pk_q;
      out_o.child_tag    <= ctag_q;
      out_o.child_known  <= ck_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      count_q  <= '0;
      scan_q   <= '0;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      count_q  <= count_d;
      scan_q   <= scan_d;
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_o.valid = ovalid_q;

endmodule

/* design/parent_chain_cycle_detector_unit.sv */
// Channel | Dir | Payload                                          | Beat
// in_i    | in  | action, first_handle, second_handle, name_tag    | valid & ready
// out_o   | out | status, parent_tag, parent_known, child_tag,     | valid & ready
//         |     | child_known                                      |
//
// A track or null-handle beat passes the engine through S_IDLE and S_DONE;
// its result is loaded into the output register on leaving S_DONE.
// An assign beat scans the table for the child, then per followed link does
// one table scan plus a read of that entry's link; a cycle adds one more scan.
// The worst case is set by the single read port of the entry memory.
// The two-entry input queue keeps accepting beats while the engine works or
// the result waits, until it holds two.
// Reset clears the entry count and all control; the table itself needs no clear.
module parent_chain_cycle_detector_unit #(
  parameter int unsigned TABLE_ENTRIES = pccd_pkg::TableEntriesDefault,
  parameter int unsigned HANDLE_BITS   = pccd_pkg::HandleBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pccd_in_if.sink     in_i,
  pccd_out_if.source  out_o
);

  // Classified command between queue and engine.
  logic           cmd_valid;
  logic           cmd_ready;
  pccd_pkg::cmd_t cmd;

  // Front: mask handles, classify, queue.
  pccd_front #(.HANDLE_BITS(HANDLE_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // Back: table, link walk, result register.
  pccd_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_o       (out_o)
  );

endmodule

/* design/pccd_checker.sv */
module pccd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [pccd_pkg::StatusW-1:0] out_status_i,
  input logic [pccd_pkg::TagW-1:0]    out_ptag_i,
  input logic                         out_pknown_i,
  input logic [pccd_pkg::TagW-1:0]    out_ctag_i,
  input logic                         out_cknown_i
);

  // Hold a stalled result.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i))
    else $error("result dropped under stall");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_status_i <= pccd_pkg::StNull)
    else $error("bad status");

  a_tags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != pccd_pkg::StCycle |->
      out_ptag_i == '0 && out_ctag_i == '0 && !out_pknown_i && !out_cknown_i)
    else $error("tags set without cycle");

  a_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (!out_pknown_i || !out_cknown_i) |->
      (out_pknown_i || out_ptag_i == '0) && (out_cknown_i || out_ctag_i == '0))
    else $error("tag without known entry");

endmodule

bind parent_chain_cycle_detector_unit pccd_checker u_pccd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_ptag_i   (out_o.parent_tag),
  .out_pknown_i (out_o.parent_known),
  .out_ctag_i   (out_o.child_tag),
  .out_cknown_i (out_o.child_known)
);
